// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Holds the pipeline payload carried from cell to cell and the register codes.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int DivBits = 64;

	// configuration register indexes
	localparam logic [1:0] RegCalibTemp   = 2'd0;
	localparam logic [1:0] RegCalibPressA = 2'd1;
	localparam logic [1:0] RegCalibPressB = 2'd2;
	localparam logic [1:0] RegCalibPressC = 2'd3;

	// one beat travelling through the divider row
	typedef struct packed {
		logic               vld;      // beat present
		logic               neg;      // quotient must be negated
		logic               zero_div; // divisor was zero
		logic [63:0]        rem;      // partial remainder
		logic [63:0]        quo;      // dividend shifting out, quotient shifting in
		logic [63:0]        dvs;      // divisor magnitude
		logic [31:0]        tfine;    // fine temperature carried along the row
		logic [31:0]        temp;     // temperature result
	} div_beat_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		sx16 = {{48{v[15]}}, v};
	endfunction

endpackage

// ===== sv/pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temp_compensation: barometric integer compensation pipeline
// Raw temperature and pressure in, compensated temperature and pressure out.
// ----------------------------------------------------------------------------
// Use: write the calibration registers through cfg_we/cfg_index/cfg_data while
// idle. Input beats on s_axis carry {raw_press, raw_temp}; one result beat per
// input appears on m_axis carrying {pressure_valid, pressure_pa,
// pressure_fixed, temperature}.
// Throughput: one beat per cycle while the receiver does not stall. The
// pipeline is the front multiply stages (12), the row of 64 division cells,
// the back stages (5) and the output register.
// The pipeline is one chain moving on a common enable; an output register
// with a skid stage parts it from m_axis so s_axis_tready only depends on
// the skid being empty. When the receiver stalls, the skid fills and the
// chain stops; no beat is lost. Reset empties the chain and clears the
// calibration registers to zero.
// ----------------------------------------------------------------------------
module pressure_temp_compensation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,  // raw_temp[19:0], raw_press[39:20]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata   // temperature, pressure_fixed, pressure_pa,
	                                    // pressure_valid, 7 zero bits
);

	localparam int NF = 12; // front stages
	localparam int NB = 5;  // back stages

	logic [47:0] ct_q;
	logic [63:0] cpa_q, cpb_q;
	logic [15:0] cpc_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_q <= '0; cpa_q <= '0; cpb_q <= '0; cpc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptc_pkg::RegCalibTemp:   ct_q  <= cfg_data[47:0];
				ptc_pkg::RegCalibPressA: cpa_q <= cfg_data;
				ptc_pkg::RegCalibPressB: cpb_q <= cfg_data;
				ptc_pkg::RegCalibPressC: cpc_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// coefficients
	logic [31:0] t1, t2, t3;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, ct_q[15:0]};
	assign t2 = {{16{ct_q[31]}}, ct_q[31:16]};
	assign t3 = {{16{ct_q[47]}}, ct_q[47:32]};
	assign p1 = {48'd0, cpa_q[15:0]};
	assign p2 = ptc_pkg::sx16(cpa_q[31:16]);
	assign p3 = ptc_pkg::sx16(cpa_q[47:32]);
	assign p4 = ptc_pkg::sx16(cpa_q[63:48]);
	assign p5 = ptc_pkg::sx16(cpb_q[15:0]);
	assign p6 = ptc_pkg::sx16(cpb_q[31:16]);
	assign p7 = ptc_pkg::sx16(cpb_q[47:32]);
	assign p8 = ptc_pkg::sx16(cpb_q[63:48]);
	assign p9 = ptc_pkg::sx16(cpc_q);

	// skid/output register and chain enable
	logic        out_vld_q, skid_vld_q;
	logic [95:0] out_q, skid_q;
	logic        en;
	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	// ---------------- front stages ----------------
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic [19:0] adp_s1, adp_s2, adp_s3, adp_s4, adp_s5, adp_s6, adp_s7, adp_s8,
	             adp_s9, adp_s10, adp_s11;
	logic [31:0] a_s1, b_s1, tv1_s2, bb_s2, tv1_s3, tv2_s3, tf_s4, tf_s5, tf_s6,
	             tf_s7, tf_s8, tf_s9, tf_s10, tf_s11, tf_s12;
	logic [31:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11,
	             temp_s12;
	logic [63:0] v1_s5, vv_s6, v1p5_s6, v1p2_s6, vv_s7, v1p5_s7, v1p2_s7,
	             v2a_s7, v1a_s7, v2_s8, v1b_s8, v2_s9, v1c_s9, v2_s10, v1d_s10, num_s10,
	             num_s11, dvd_s12, dvs_s12, v1d_s11;
	logic        neg_s12, zd_s12;
	logic [63:0] tfe;
	logic [63:0] v1pre;
	logic [63:0] pneg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <=
				{s_axis_tvalid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9,
				 v_s10, v_s11};
		end
	end

	assign tfe   = {{32{tf_s4[31]}}, tf_s4};
	assign v1pre = $signed(v1d_s10) + 64'h0000_8000_0000_0000;
	assign pneg  = $signed(num_s11);

	// temperature then pressure divisor and dividend, multiplies spread over the front stages
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= {15'd0, s_axis_tdata[19:3]} - {t1[30:0], 1'b0};
			b_s1    <= {16'd0, s_axis_tdata[19:4]} - t1;
			adp_s1  <= s_axis_tdata[39:20];
			tv1_s2  <= 32'($signed(a_s1 * t2) >>> 11);
			bb_s2   <= 32'($signed(b_s1 * b_s1) >>> 12);
			adp_s2  <= adp_s1;
			tv1_s3  <= tv1_s2;
			tv2_s3  <= 32'($signed(bb_s2 * t3) >>> 14);
			adp_s3  <= adp_s2;
			tf_s4   <= tv1_s3 + tv2_s3;
			adp_s4  <= adp_s3;
			tf_s5   <= tf_s4;
			temp_s5 <= 32'($signed(tf_s4 * 32'd5 + 32'd128) >>> 8);
			v1_s5   <= tfe - 64'd128000;
			adp_s5  <= adp_s4;
			tf_s6   <= tf_s5; temp_s6 <= temp_s5; adp_s6 <= adp_s5;
			vv_s6   <= 64'($signed(v1_s5[32:0]) * $signed(v1_s5[32:0]));
			v1p5_s6 <= v1_s5 * p5;
			v1p2_s6 <= v1_s5 * p2;
			tf_s7   <= tf_s6; temp_s7 <= temp_s6; adp_s7 <= adp_s6;
			vv_s7   <= vv_s6; v1p5_s7 <= v1p5_s6; v1p2_s7 <= v1p2_s6;
			v2a_s7  <= vv_s6 * p6;
			v1a_s7  <= vv_s6 * p3;
			tf_s8   <= tf_s7; temp_s8 <= temp_s7; adp_s8 <= adp_s7;
			v2_s8   <= v2a_s7 + (v1p5_s7 << 17) + (p4 << 35);
			v1b_s8  <= 64'($signed(v1a_s7) >>> 8) + (v1p2_s7 << 12);
			tf_s9   <= tf_s8; temp_s9 <= temp_s8; adp_s9 <= adp_s8;
			v2_s9   <= v2_s8;
			v1c_s9  <= ((64'd1 << 47) + v1b_s8) * p1;
			tf_s10  <= tf_s9; temp_s10 <= temp_s9; adp_s10 <= adp_s9;
			v2_s10  <= v2_s9;
			v1d_s10 <= 64'($signed(v1c_s9) >>> 33);
			num_s10 <= ((64'd1048576 - {44'd0, adp_s9}) << 31) - v2_s9;
			tf_s11  <= tf_s10; temp_s11 <= temp_s10; adp_s11 <= adp_s10;
			v1d_s11 <= v1d_s10;
			num_s11 <= num_s10 * 64'd3125;
			tf_s12  <= tf_s11; temp_s12 <= temp_s11;
			zd_s12  <= (v1d_s11 == 64'd0);
			neg_s12 <= num_s11[63] ^ v1d_s11[63];
			dvd_s12 <= num_s11[63] ? 64'd0 - num_s11 : num_s11;
			dvs_s12 <= v1d_s11[63] ? 64'd0 - v1d_s11 : v1d_s11;
		end
	end

	// ---------------- division row ----------------
	ptc_pkg::div_beat_t row [0:ptc_pkg::DivBits];
	always_comb begin
		row[0].vld      = v_s12;
		row[0].neg      = neg_s12;
		row[0].zero_div = zd_s12;
		row[0].rem      = '0;
		row[0].quo      = dvd_s12;
		row[0].dvs      = dvs_s12;
		row[0].tfine    = tf_s12;
		row[0].temp     = temp_s12;
	end

	for (genvar i = 0; i < ptc_pkg::DivBits; i++) begin : g_cell
		ptc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (row[i]),
			.dout   (row[i+1])
		);
	end

	// ---------------- back stages ----------------
	ptc_pkg::div_beat_t dq;
	assign dq = row[ptc_pkg::DivBits];

	logic        vb_s1, vb_s2, vb_s3, vb_s4, vb_s5;
	logic        zd_b1, zd_b2, zd_b3, zd_b4, zd_b5;
	logic [31:0] tp_b1, tp_b2, tp_b3, tp_b4, tp_b5;
	logic [63:0] p_b1, ps_b1, p_b2, ps_b2, psp_b2, p8p_b2, p_b3, ll_b3, v2_b3;
	logic [31:0] cr_b3;
	logic [63:0] p_b4, v1_b4, v2_b4;
	logic [31:0] fx_b5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vb_s1, vb_s2, vb_s3, vb_s4, vb_s5} <= '0;
		end else if (en) begin
			{vb_s1, vb_s2, vb_s3, vb_s4, vb_s5} <= {dq.vld, vb_s1, vb_s2, vb_s3, vb_s4};
		end
	end

	logic [63:0] qs;
	logic [63:0] sum_b4;
	assign qs     = dq.neg ? 64'd0 - dq.quo : dq.quo;
	assign sum_b4 = p_b4 + v1_b4 + v2_b4;

	// finish the pressure formula; the square term is split into 32-bit halves
	always_ff @(posedge clk) begin
		if (en) begin
			zd_b1  <= dq.zero_div; tp_b1 <= dq.temp;
			p_b1   <= qs;
			ps_b1  <= 64'($signed(qs) >>> 13);
			zd_b2  <= zd_b1; tp_b2 <= tp_b1; p_b2 <= p_b1; ps_b2 <= ps_b1;
			psp_b2 <= p9 * ps_b1;
			p8p_b2 <= p8 * p_b1;
			zd_b3  <= zd_b2; tp_b3 <= tp_b2; p_b3 <= p_b2;
			ll_b3  <= 64'(psp_b2[31:0]) * 64'(ps_b2[31:0]);
			cr_b3  <= psp_b2[31:0] * ps_b2[63:32] + psp_b2[63:32] * ps_b2[31:0];
			v2_b3  <= 64'($signed(p8p_b2) >>> 19);
			zd_b4  <= zd_b3; tp_b4 <= tp_b3; p_b4 <= p_b3; v2_b4 <= v2_b3;
			v1_b4  <= 64'($signed(ll_b3 + {cr_b3, 32'd0}) >>> 25);
			zd_b5  <= zd_b4; tp_b5 <= tp_b4;
			fx_b5  <= 32'(64'($signed(sum_b4) >>> 8) + (p7 << 4));
		end
	end

	logic [95:0] res;
	assign res = {7'd0, !zd_b5, zd_b5 ? 24'd0 : fx_b5[31:8],
	              zd_b5 ? 32'd0 : fx_b5, tp_b5};

	// output register with skid: capture while chain advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (m_axis_tready) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (!out_vld_q || m_axis_tready) begin
				out_vld_q <= vb_s5;
			end else if (vb_s5) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_axis_tready) out_q <= skid_q;
		end else if (!out_vld_q || m_axis_tready) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	logic unused;
	assign unused = ^{dq.tfine, dq.rem, adp_s11, tf_s5, vv_s7, pneg, v1pre};

endmodule

// ===== sv/ptc_div_cell.sv =====
// ----------------------------------------------------------------------------
// ptc_div_cell: one restoring-division step
// Shifts one dividend bit into the remainder and trial-subtracts the divisor.
// ----------------------------------------------------------------------------
module ptc_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  ptc_pkg::div_beat_t     din,
	output ptc_pkg::div_beat_t     dout
);

	logic [64:0] trial;
	logic [63:0] shrem;
	ptc_pkg::div_beat_t nxt;
	logic               vld_q;
	ptc_pkg::div_beat_t data_q;

	// shift, subtract, keep or restore
	always_comb begin
		nxt   = din;
		shrem = {din.rem[62:0], din.quo[63]};
		trial = {1'b0, shrem} - {1'b0, din.dvs};
		if (!trial[64] && !din.rem[63]) begin
			nxt.rem = trial[63:0];
			nxt.quo = {din.quo[62:0], 1'b1};
		end else if (din.rem[63]) begin
			// remainder carries out of 64 bits: subtraction always fits
			nxt.rem = shrem - din.dvs;
			nxt.quo = {din.quo[62:0], 1'b1};
		end else begin
			nxt.rem = shrem;
			nxt.quo = {din.quo[62:0], 1'b0};
		end
	end

	// hold control under reset, advance when enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	// present the beat with its registered valid flag
	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: pressure/temperature compensation testbench
// Drives raw temperature/pressure beats, predicts each compensated result in
// 64-bit two's complement arithmetic and compares it field by field on m_axis.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [31:0] temperature;
		logic [31:0] press_fixed;
		logic [23:0] press_pa;
		logic        press_valid;
	} comp_result_t;

	typedef struct {
		logic [19:0]  raw_t;
		logic [19:0]  raw_p;
		bit           has_exp;
		comp_result_t exp_res;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata;   // raw_temp[19:0], raw_press[39:20]
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;   // temperature, pressure_fixed, pressure_pa, valid, pad

	// calibration copy
	logic [47:0] cal_t;
	logic [63:0] cal_pa, cal_pb;
	logic [15:0] cal_pc;

	comp_result_t result_q[$];
	int  n_err, n_beats, n_invalid;
	int  src_idle_pct, snk_idle_pct;
	bit  hold_off;

	pressure_temp_compensation dut (.*);

	// clock
	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	// compensate one raw pair with the current calibration
	function automatic comp_result_t compensate(input logic [19:0] adt, input logic [19:0] adp);
		logic [31:0] t1, t2, t3, a, b, tv1, tv2, tfine, temp;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] v1, v2, p, ps, num, ua, ub, q;
		comp_result_t r;
		t1 = {16'd0, cal_t[15:0]};
		t2 = {{16{cal_t[31]}}, cal_t[31:16]};
		t3 = {{16{cal_t[47]}}, cal_t[47:32]};
		a = {12'd0, adt} >> 3;
		a = a - (t1 << 1);
		tv1 = 32'(a * t2);
		tv1 = $signed(tv1) >>> 11;
		b = ({12'd0, adt} >> 4) - t1;
		tv2 = 32'(b * b);
		tv2 = $signed(tv2) >>> 12;
		tv2 = 32'(tv2 * t3);
		tv2 = $signed(tv2) >>> 14;
		tfine = tv1 + tv2;
		temp = 32'(tfine * 32'd5) + 32'd128;
		temp = $signed(temp) >>> 8;
		p1 = {48'd0, cal_pa[15:0]};
		p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
		p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
		p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
		p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
		p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
		p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
		p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
		p9 = {{48{cal_pc[15]}}, cal_pc};
		v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
		r.temperature = temp;
		if (v1 == 64'd0) begin
			r.press_fixed = '0;
			r.press_pa = '0;
			r.press_valid = 1'b0;
			return r;
		end
		p = 64'd1048576 - {44'd0, adp};
		num = ((p << 31) - v2) * 64'd3125;
		ua = num[63] ? -num : num;
		ub = v1[63] ? -v1 : v1;
		q = ua / ub;
		p = (num[63] != v1[63]) ? -q : q;
		ps = asr64(p, 13);
		v1 = asr64(p9 * ps * ps, 25);
		v2 = asr64(p8 * p, 19);
		p = asr64(p + v1 + v2, 8) + (p7 << 4);
		r.press_fixed = p[31:0];
		r.press_pa = p[31:8];
		r.press_valid = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [95:0] got,
		input logic [95:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		n_err++;
	endtask

	// write one calibration register; the block is idle here
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ptc_pkg::RegCalibTemp:   cal_t  = val[47:0];
			ptc_pkg::RegCalibPressA: cal_pa = val;
			ptc_pkg::RegCalibPressB: cal_pb = val;
			ptc_pkg::RegCalibPressC: cal_pc = val[15:0];
		endcase
	endtask

	task automatic write_all(input logic [47:0] ct, input logic [63:0] pa,
		input logic [63:0] pb, input logic [15:0] pc);
		write_reg(ptc_pkg::RegCalibTemp, {16'd0, ct});
		write_reg(ptc_pkg::RegCalibPressA, pa);
		write_reg(ptc_pkg::RegCalibPressB, pb);
		write_reg(ptc_pkg::RegCalibPressC, {48'd0, pc});
	endtask

	// offer one beat, hold until accepted
	task automatic send_beat(input logic [19:0] rt, input logic [19:0] rp,
		input bit has_exp, input comp_result_t exp_res);
		comp_result_t pred;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {rp, rt};
		pred = compensate(rt, rp);
		if (has_exp && pred != exp_res)
			report_mismatch("table row", 96'(pred), 96'(exp_res));
		result_q.push_back(has_exp ? exp_res : pred);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// check each accepted result beat
	always @(posedge clk) begin
		comp_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.temperature = m_axis_tdata[31:0];
			got.press_fixed = m_axis_tdata[63:32];
			got.press_pa    = m_axis_tdata[87:64];
			got.press_valid = m_axis_tdata[88];
			n_beats++;
			if (!got.press_valid) n_invalid++;
			if (result_q.size() == 0) begin
				report_mismatch("unexpected beat", 96'(got.temperature), 96'd0);
			end else begin
				want = result_q.pop_front();
				if (got.temperature != want.temperature)
					report_mismatch("temperature", 96'(got.temperature),
						96'(want.temperature));
				if (got.press_fixed != want.press_fixed)
					report_mismatch("pressure_fixed", 96'(got.press_fixed),
						96'(want.press_fixed));
				if (got.press_pa != want.press_pa)
					report_mismatch("pressure_pa", 96'(got.press_pa), 96'(want.press_pa));
				if (got.press_valid != want.press_valid)
					report_mismatch("pressure_valid", 96'(got.press_valid),
						96'(want.press_valid));
			end
		end
	end

	// run limit
	initial begin
		#20ms;
		$display("timeout");
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64;
		return {$urandom, $urandom};
	endfunction

	// random calibration near typical sensor values, or fully random
	task automatic random_calib;
		if ($urandom_range(3) == 0) begin
			write_all(48'({$urandom, $urandom}), rand64(), rand64(), 16'($urandom));
		end else begin
			write_all({16'(-16'sd500 + $urandom_range(1000)),
				16'(26000 + $urandom_range(2000)), 16'(27000 + $urandom_range(2000))},
				{16'(3000 + $urandom_range(200)), 16'(-16'sd10 + $urandom_range(20)),
				16'(-16'sd10700 + $urandom_range(200)), 16'(36000 + $urandom_range(2000))},
				{16'($urandom_range(65535)), 16'(-16'sd7), 16'(140 + $urandom_range(20)),
				16'(-16'sd12000 + $urandom_range(1000))},
				16'(5000 + $urandom_range(2000)));
		end
	endtask

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		comp_result_t zero_res;
		int phase, i;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = ptc_pkg::RegCalibTemp; cfg_data = '0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0;
		hold_off = 1'b0;
		cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
		n_err = 0; n_beats = 0; n_invalid = 0;
		src_idle_pct = 0; snk_idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset all coefficients are zero: temperature 0, divisor 0
		zero_res = '0;
		row.has_exp = 1'b1; row.exp_res = zero_res;
		row.raw_t = 20'd0;       row.raw_p = 20'd0;       rows.push_back(row);
		row.raw_t = 20'hFFFFF;   row.raw_p = 20'hFFFFF;   rows.push_back(row);
		row.raw_t = 20'h80000;   row.raw_p = 20'h7FFFF;   rows.push_back(row);
		foreach (rows[k]) send_beat(rows[k].raw_t, rows[k].raw_p, 1'b1, rows[k].exp_res);
		drain();

		// typical calibration, field extremes and mid-range readings
		write_all({16'd50, 16'd26435, 16'd27504}, {-16'sd3000, -16'sd10, 16'd0, 16'd36477} ==
			0 ? 64'd0 : {16'd2855, -16'sd10, 16'd6, 16'd36477},
			{-16'sd14600, -16'sd7, 16'd140, -16'sd64}, 16'd6000);
		rows.delete();
		row.has_exp = 1'b0;
		row.raw_t = 20'd0;     row.raw_p = 20'd0;     rows.push_back(row);
		row.raw_t = 20'hFFFFF; row.raw_p = 20'hFFFFF; rows.push_back(row);
		row.raw_t = 20'd0;     row.raw_p = 20'hFFFFF; rows.push_back(row);
		row.raw_t = 20'hFFFFF; row.raw_p = 20'd0;     rows.push_back(row);
		row.raw_t = 20'd519888; row.raw_p = 20'd415148; rows.push_back(row);
		row.raw_t = 20'h55555; row.raw_p = 20'hAAAAA; rows.push_back(row);
		row.raw_t = 20'hAAAAA; row.raw_p = 20'h55555; rows.push_back(row);
		foreach (rows[k]) send_beat(rows[k].raw_t, rows[k].raw_p, 1'b0, zero_res);
		drain();

		// extreme coefficients: wrap-around in both paths; P1 zero gives zero divisor
		write_all('1, '1, '1, 16'hFFFF);
		for (i = 0; i < 4; i++) send_beat(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0,
			1'b0, zero_res);
		drain();
		write_all({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
			{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
		for (i = 0; i < 4; i++) send_beat(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0,
			1'b0, zero_res);
		drain();
		write_all(48'({$urandom, $urandom}), 64'hFFFF_FFFF_FFFF_0000, rand64(), 16'h7FFF);
		send_beat(20'h12345, 20'h6789A, 1'b0, zero_res);
		drain();

		// random phases: receiver idles most, then sender, then neither
		for (phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 82 : 0;
			snk_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 23 : 0;
			for (int s = 0; s < 4; s++) begin
				random_calib();
				if (phase == 2 && s == 0) begin
					// long receiver hold-off while the sender keeps offering
					fork
						begin
							hold_off = 1'b1;
							repeat (300) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				for (i = 0; i < 165; i++)
					send_beat(20'($urandom), 20'($urandom), 1'b0, zero_res);
				drain();
			end
		end

		$display("run covered %0d result beats over several calibration sets, %0d with",
			n_beats, n_invalid);
		$display("a zero divisor, under sender and receiver stalls and one long hold-off");
		if (n_err == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== pressure_temp_compensation.f =====
sv/ptc_pkg.sv
sv/ptc_div_cell.sv
sv/pressure_temp_compensation.sv
tb/tb_top.sv
